// ===== src/axrot_pkg.sv =====
package axrot_pkg;

    // CORDIC iteration count; one pipeline stage per iteration
    localparam int CORDIC_STEPS = 16;

    localparam longint K_INF       = 64'sd652032874;
    localparam longint CORDIC_GAIN =
        K_INF + (2 * K_INF) / (3 * (longint'(1) << (2 * CORDIC_STEPS)));

    localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;

    // Vector operands and cross/dot results carried beside the CORDIC
    typedef struct packed {
        logic [2:0][31:0] v;
        logic [2:0][17:0] a;
        logic [2:0][35:0] k;
        logic [35:0]      dq;
    } side_t;

    // Reduced angle in Q.30 and the sign fix for cos/sin
    typedef struct packed {
        logic [32:0] z;
        logic        flip;
    } ang_t;

    // Truncated atan(2^-i) in Q.30
    function automatic logic [31:0] atan_q30(input int i);
        logic [31:0] r;
        case (i)
            0:  r = 32'd843314856;
            1:  r = 32'd497837829;
            2:  r = 32'd263043836;
            3:  r = 32'd133525158;
            4:  r = 32'd67021686;
            5:  r = 32'd33543515;
            6:  r = 32'd16775850;
            7:  r = 32'd8388437;
            8:  r = 32'd4194282;
            9:  r = 32'd2097149;
            10: r = 32'd1048575;
            11: r = 32'd524287;
            12: r = 32'd262143;
            13: r = 32'd131071;
            14: r = 32'd65535;
            15: r = 32'd32767;
            16: r = 32'd16383;
            17: r = 32'd8191;
            18: r = 32'd4095;
            19: r = 32'd2047;
            20: r = 32'd1023;
            21: r = 32'd511;
            22: r = 32'd255;
            23: r = 32'd127;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== src/axrot_prod.sv =====
module axrot_prod
    import axrot_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_vld,
    input  logic [2:0][31:0] in_v,
    input  logic [2:0][17:0] in_a,
    input  ang_t             in_ang,
    output logic             out_vld,
    output side_t            out_side,
    output ang_t             out_ang
);

    logic [1:0]             vld_reg;
    logic signed [49:0]     p_reg [9];
    logic signed [49:0]     p_next [9];
    logic [2:0][31:0]       v1_reg;
    logic [2:0][17:0]       a1_reg;
    ang_t                   ang1_reg;
    side_t                  side_reg;
    side_t                  side_next;
    ang_t                   ang2_reg;
    logic signed [50:0]     diff [3];
    logic signed [50:0]     kr [3];
    logic signed [51:0]     dsum;

    always_comb
    begin
        // cross product terms, then dot product terms
        p_next[0] = $signed(in_a[1]) * $signed(in_v[2]);
        p_next[1] = $signed(in_a[2]) * $signed(in_v[1]);
        p_next[2] = $signed(in_a[2]) * $signed(in_v[0]);
        p_next[3] = $signed(in_a[0]) * $signed(in_v[2]);
        p_next[4] = $signed(in_a[0]) * $signed(in_v[1]);
        p_next[5] = $signed(in_a[1]) * $signed(in_v[0]);
        p_next[6] = $signed(in_a[0]) * $signed(in_v[0]);
        p_next[7] = $signed(in_a[1]) * $signed(in_v[1]);
        p_next[8] = $signed(in_a[2]) * $signed(in_v[2]);
    end

    always_comb
    begin
        side_next.v = v1_reg;
        side_next.a = a1_reg;
        for (int j = 0; j < 3; j++)
        begin
            diff[j] = 51'(p_reg[2*j]) - 51'(p_reg[2*j+1]);
            kr[j]   = diff[j] + 51'sd32768;
            side_next.k[j] = 36'($signed(kr[j][50:16]));
        end
        dsum = 52'(p_reg[6]) + 52'(p_reg[7]) + 52'(p_reg[8]) + 52'sd32768;
        side_next.dq = dsum[51:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 9; j++)
                p_reg[j] <= p_next[j];
            v1_reg   <= in_v;
            a1_reg   <= in_a;
            ang1_reg <= in_ang;
            side_reg <= side_next;
            ang2_reg <= ang1_reg;
        end
    end

    assign out_vld  = vld_reg[1];
    assign out_side = side_reg;
    assign out_ang  = ang2_reg;

endmodule

// ===== src/axrot_cordic.sv =====
module axrot_cordic
    import axrot_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  ang_t               in_ang,
    input  side_t              in_side,
    output logic               out_vld,
    output logic signed [21:0] cos20,
    output logic signed [21:0] sin20,
    output logic signed [22:0] omc20,
    output side_t              out_side
);

    logic [CORDIC_STEPS-1:0]  vld_reg;
    logic signed [31:0]       x_reg [CORDIC_STEPS];
    logic signed [31:0]       y_reg [CORDIC_STEPS];
    logic signed [32:0]       z_reg [CORDIC_STEPS];
    logic                     flip_reg [CORDIC_STEPS];
    side_t                    side_reg [CORDIC_STEPS];

    logic                     vo_reg;
    logic signed [21:0]       c_reg;
    logic signed [21:0]       s_reg;
    logic signed [22:0]       omc_reg;
    side_t                    so_reg;

    genvar i;
    generate
        for (i = 0; i < CORDIC_STEPS; i++)
        begin : g_step
            logic signed [31:0] xi, yi, xn, yn;
            logic signed [32:0] zi, zn;
            logic signed [32:0] at;
            logic               fi;
            side_t              si;
            logic               vi;

            if (i == 0)
            begin : g_first
                assign xi = $signed(32'(CORDIC_GAIN));
                assign yi = '0;
                assign zi = $signed(in_ang.z);
                assign fi = in_ang.flip;
                assign si = in_side;
                assign vi = in_vld;
            end
            else
            begin : g_rest
                assign xi = x_reg[i-1];
                assign yi = y_reg[i-1];
                assign zi = z_reg[i-1];
                assign fi = flip_reg[i-1];
                assign si = side_reg[i-1];
                assign vi = vld_reg[i-1];
            end

            assign at = $signed({1'b0, atan_q30(i)});

            always_comb
            begin
                if (!zi[32])
                begin
                    xn = xi - (yi >>> i);
                    yn = yi + (xi >>> i);
                    zn = zi - at;
                end
                else
                begin
                    xn = xi + (yi >>> i);
                    yn = yi - (xi >>> i);
                    zn = zi + at;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[i] <= 1'b0;
                else if (en)
                    vld_reg[i] <= vi;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[i]    <= xn;
                    y_reg[i]    <= yn;
                    z_reg[i]    <= zn;
                    flip_reg[i] <= fi;
                    side_reg[i] <= si;
                end
            end
        end
    endgenerate

    logic signed [31:0] xr, yr;
    logic signed [21:0] c_next, s_next;

    always_comb
    begin
        // round Q.30 to Q.20, then undo the half-turn fold
        xr = x_reg[CORDIC_STEPS-1] + 32'sd512;
        yr = y_reg[CORDIC_STEPS-1] + 32'sd512;
        c_next = xr[31:10];
        s_next = yr[31:10];
        if (flip_reg[CORDIC_STEPS-1])
        begin
            c_next = -c_next;
            s_next = -s_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vo_reg <= 1'b0;
        else if (en)
            vo_reg <= vld_reg[CORDIC_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg   <= c_next;
            s_reg   <= s_next;
            omc_reg <= 23'sd1048576 - 23'(c_next);
            so_reg  <= side_reg[CORDIC_STEPS-1];
        end
    end

    assign out_vld  = vo_reg;
    assign cos20    = c_reg;
    assign sin20    = s_reg;
    assign omc20    = omc_reg;
    assign out_side = so_reg;

endmodule

// ===== src/axrot_final.sv =====
module axrot_final
    import axrot_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  logic signed [21:0] cos20,
    input  logic signed [21:0] sin20,
    input  logic signed [22:0] omc20,
    input  side_t              in_side,
    output logic               out_vld,
    output logic [2:0][31:0]   rot,
    output logic               sat
);

    logic [3:0]           vld_reg;
    // stage 1
    logic signed [53:0]   pvc_reg [3];
    logic signed [57:0]   pks_reg [3];
    logic signed [58:0]   pdo_reg;
    logic [2:0][17:0]     a1_reg;
    // stage 2
    logic signed [38:0]   dt_reg;
    logic signed [58:0]   s1_reg [3];
    logic [2:0][17:0]     a2_reg;
    // stage 3
    logic signed [56:0]   pad_reg [3];
    logic signed [58:0]   s2_reg [3];
    // stage 4
    logic [2:0][31:0]     rot_reg;
    logic                 sat_reg;

    logic signed [58:0]   pdo_rnd;
    logic signed [61:0]   sum [3];
    logic signed [41:0]   r [3];
    logic [2:0][31:0]     rot_next;
    logic                 sat_next;

    assign pdo_rnd = pdo_reg + 59'sd524288;

    always_comb
    begin
        sat_next = 1'b0;
        for (int j = 0; j < 3; j++)
        begin
            sum[j] = 62'(s2_reg[j]) + (62'(pad_reg[j]) <<< 4) + 62'sd524288;
            r[j]   = sum[j][61:20];
            // clip to the Q16.16 range
            if (r[j] > 42'sd2147483647)
            begin
                rot_next[j] = 32'h7fff_ffff;
                sat_next    = 1'b1;
            end
            else if (r[j] < -42'sd2147483648)
            begin
                rot_next[j] = 32'h8000_0000;
                sat_next    = 1'b1;
            end
            else
                rot_next[j] = r[j][31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[2:0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                pvc_reg[j] <= $signed(in_side.v[j]) * cos20;
                pks_reg[j] <= $signed(in_side.k[j]) * sin20;
                s1_reg[j]  <= 59'(pvc_reg[j]) + 59'(pks_reg[j]);
                pad_reg[j] <= $signed(a2_reg[j]) * dt_reg;
                s2_reg[j]  <= s1_reg[j];
            end
            pdo_reg <= $signed(in_side.dq) * omc20;
            a1_reg  <= in_side.a;
            dt_reg  <= pdo_rnd[58:20];
            a2_reg  <= a1_reg;
            rot_reg <= rot_next;
            sat_reg <= sat_next;
        end
    end

    assign out_vld = vld_reg[3];
    assign rot     = rot_reg;
    assign sat     = sat_reg;

endmodule

// ===== src/vector_axis_angle_rotation.sv =====
// Axis-angle rotation of a 3D vector by the Rodrigues formula.
// Input stream (s_axis): one request per beat carrying the target vector
// (Q16.16), a unit axis (Q2.16) and an angle in radians (Q3.16).
// Output stream (m_axis): the rotated vector (Q16.16, saturated) in tdata and
// a saturation flag in tuser, one result per request, in request order.
// Cos and sin come from a 16-iteration CORDIC, one register stage per
// iteration; the cross and dot products run beside it and travel with it.
// From acceptance to m_axis_tvalid a request passes one input stage, two
// product stages, the CORDIC stages, one rounding stage and four stages of
// multiply, sum and clip.
// Throughput: one request per cycle, limited only by the output handshake.
// All stages advance together; while a result waits with m_axis_tready low
// the whole pipeline holds and s_axis_tready drops, so nothing is lost or
// repeated. Gaps between requests are kept and reach the output as gaps.
// Reset clears the valid bits only; the block keeps no other state.
module vector_axis_angle_rotation
    import axrot_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // target_x, target_y, target_z, axis_x, axis_y, axis_z, angle, zero pad
    input  logic [175:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // rotated_x, rotated_y, rotated_z
    output logic [95:0]  m_axis_tdata,
    // saturated
    output logic [0:0]   m_axis_tuser
);

    logic             en;
    logic             acc;
    logic             s0_vld_reg;
    logic [2:0][31:0] v0_reg;
    logic [2:0][17:0] a0_reg;
    ang_t             ang0_reg;
    ang_t             ang0_next;
    logic signed [33:0] zw;

    logic             p_vld;
    side_t            p_side;
    ang_t             p_ang;
    logic             c_vld;
    logic signed [21:0] c_cos;
    logic signed [21:0] c_sin;
    logic signed [22:0] c_omc;
    side_t            c_side;
    logic [2:0][31:0] rot;
    logic             sat;

    // advance whenever the output register is empty or being drained
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign acc           = s_axis_tvalid && s_axis_tready;

    // fold the angle into +-pi/2 and remember to negate cos and sin
    always_comb
    begin
        zw = 34'($signed(s_axis_tdata[168:150])) <<< 14;
        ang0_next.flip = 1'b0;
        if (zw > HALF_PI_Q30)
        begin
            zw = zw - PI_Q30;
            ang0_next.flip = 1'b1;
        end
        else if (zw < -HALF_PI_Q30)
        begin
            zw = zw + PI_Q30;
            ang0_next.flip = 1'b1;
        end
        ang0_next.z = zw[32:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_vld_reg <= 1'b0;
        else if (en)
            s0_vld_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v0_reg[0] <= s_axis_tdata[31:0];
            v0_reg[1] <= s_axis_tdata[63:32];
            v0_reg[2] <= s_axis_tdata[95:64];
            a0_reg[0] <= s_axis_tdata[113:96];
            a0_reg[1] <= s_axis_tdata[131:114];
            a0_reg[2] <= s_axis_tdata[149:132];
            ang0_reg  <= ang0_next;
        end
    end

    axrot_prod u_prod (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s0_vld_reg),
        .in_v     (v0_reg),
        .in_a     (a0_reg),
        .in_ang   (ang0_reg),
        .out_vld  (p_vld),
        .out_side (p_side),
        .out_ang  (p_ang)
    );

    axrot_cordic u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (p_vld),
        .in_ang   (p_ang),
        .in_side  (p_side),
        .out_vld  (c_vld),
        .cos20    (c_cos),
        .sin20    (c_sin),
        .omc20    (c_omc),
        .out_side (c_side)
    );

    axrot_final u_final (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (c_vld),
        .cos20   (c_cos),
        .sin20   (c_sin),
        .omc20   (c_omc),
        .in_side (c_side),
        .out_vld (m_axis_tvalid),
        .rot     (rot),
        .sat     (sat)
    );

    assign m_axis_tdata = {rot[2], rot[1], rot[0]};
    assign m_axis_tuser = sat;

    // an accepted request lands in the input stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> s0_vld_reg)
        else $error("accepted request missing from input stage");

    // saturation flag only with a clipped component
    a_sat_clip: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && sat) |->
            (rot[0] == 32'h7fff_ffff || rot[0] == 32'h8000_0000 ||
             rot[1] == 32'h7fff_ffff || rot[1] == 32'h8000_0000 ||
             rot[2] == 32'h7fff_ffff || rot[2] == 32'h8000_0000))
        else $error("saturation flag without clipped component");

    // CORDIC cosine stays near the unit range
    a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
        c_vld |-> (c_cos <= 22'sd1050000 && c_cos >= -22'sd1050000))
        else $error("cosine out of range");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the axis-angle vector rotator.
// A driver streams requests from a queue on the falling edge; a monitor on the
// rising edge predicts each accepted request and checks every result in order.
module testbench;
    import axrot_pkg::*;

    // One request as it travels on the input bus
    typedef struct {
        logic signed [31:0] tx, ty, tz;
        logic signed [17:0] ax, ay, az;
        logic signed [18:0] ang;
    } rot_req_t;

    // One rotated vector with its clip flag
    typedef struct {
        logic [31:0] rx, ry, rz;
        logic        sat;
    } rot_res_t;

    localparam longint ATAN_Q30 [24] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767, 16383, 8191,
        4095, 2047, 1023, 511, 255, 127};

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [175:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [95:0]  m_axis_tdata;
    logic [0:0]   m_axis_tuser;

    rot_req_t pending_reqs[$];
    rot_res_t expected_vecs[$];
    int       idle_pct;
    int       stall_pct;
    bit       req_taken;
    int       err_count;
    int       checked_count;
    int       clipped_count;

    vector_axis_angle_rotation u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Round half up, then floor: arithmetic shift on a signed longint floors
    function automatic longint rnd_shift(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    // Pack fields from the lowest bit up, zero padding at the top
    function automatic logic [175:0] pack_req(input rot_req_t r);
        return {7'd0, r.ang, r.az, r.ay, r.ax, r.tz, r.ty, r.tx};
    endfunction

    // Work out the rotated vector straight from the bus bits
    function automatic rot_res_t rotate_vector(input logic [175:0] bus);
        longint   v [3];
        longint   a [3];
        longint   k [3];
        longint   z, x, y, nx, c20, s20, omc, d, dq, dt, sum, r;
        bit       flip;
        int       steps;
        rot_res_t res;
        v[0] = longint'($signed(bus[31:0]));
        v[1] = longint'($signed(bus[63:32]));
        v[2] = longint'($signed(bus[95:64]));
        a[0] = longint'($signed(bus[113:96]));
        a[1] = longint'($signed(bus[131:114]));
        a[2] = longint'($signed(bus[149:132]));
        z = longint'($signed(bus[168:150])) * 16384;
        flip = 1'b0;
        // fold the angle into +-pi/2 and remember to negate cos and sin
        if (z > longint'(HALF_PI_Q30))
        begin
            z = z - longint'(PI_Q30);
            flip = 1'b1;
        end
        else if (z < -longint'(HALF_PI_Q30))
        begin
            z = z + longint'(PI_Q30);
            flip = 1'b1;
        end
        steps = (CORDIC_STEPS < 1) ? 1 : ((CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS);
        x = CORDIC_GAIN;
        y = 0;
        for (int i = 0; i < steps; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - ATAN_Q30[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + ATAN_Q30[i];
            end
            x = nx;
        end
        c20 = rnd_shift(x, 10);
        s20 = rnd_shift(y, 10);
        if (flip)
        begin
            c20 = -c20;
            s20 = -s20;
        end
        omc = (longint'(1) <<< 20) - c20;
        k[0] = rnd_shift(a[1] * v[2] - a[2] * v[1], 16);
        k[1] = rnd_shift(a[2] * v[0] - a[0] * v[2], 16);
        k[2] = rnd_shift(a[0] * v[1] - a[1] * v[0], 16);
        d  = a[0] * v[0] + a[1] * v[1] + a[2] * v[2];
        dq = rnd_shift(d, 16);
        dt = rnd_shift(dq * omc, 20);
        res.sat = 1'b0;
        for (int j = 0; j < 3; j++)
        begin
            sum = v[j] * c20 + k[j] * s20 + (a[j] * dt) * 16;
            r = rnd_shift(sum, 20);
            if (r > 64'sd2147483647)
            begin
                r = 64'sd2147483647;
                res.sat = 1'b1;
            end
            else if (r < -64'sd2147483648)
            begin
                r = -64'sd2147483648;
                res.sat = 1'b1;
            end
            if (j == 0) res.rx = r[31:0];
            if (j == 1) res.ry = r[31:0];
            if (j == 2) res.rz = r[31:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
    endtask

    // Driver: change inputs on the falling edge only
    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
        if (!s_axis_tvalid || req_taken)
        begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                s_axis_tdata  <= pack_req(pending_reqs.pop_front());
                s_axis_tvalid <= 1'b1;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
        req_taken = 1'b0;
    end

    // Monitor: predict on request acceptance, check on result acceptance
    always @(posedge clk)
    begin
        rot_res_t want;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            req_taken = 1'b1;
            expected_vecs.push_back(rotate_vector(s_axis_tdata));
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_vecs.size() == 0)
            begin
                report_mismatch("unexpected result", m_axis_tdata[31:0], 32'd0);
            end
            else
            begin
                want = expected_vecs.pop_front();
                checked_count++;
                if (want.sat) clipped_count++;
                if (m_axis_tdata[31:0] !== want.rx)
                    report_mismatch("rotated_x", m_axis_tdata[31:0], want.rx);
                if (m_axis_tdata[63:32] !== want.ry)
                    report_mismatch("rotated_y", m_axis_tdata[63:32], want.ry);
                if (m_axis_tdata[95:64] !== want.rz)
                    report_mismatch("rotated_z", m_axis_tdata[95:64], want.rz);
                if (m_axis_tuser[0] !== want.sat)
                    report_mismatch("saturated", {31'd0, m_axis_tuser[0]}, {31'd0, want.sat});
            end
        end
    end

    function automatic rot_req_t make_req(input longint tx, ty, tz,
                                          input longint ax, ay, az, ang);
        rot_req_t r;
        r.tx = tx[31:0];
        r.ty = ty[31:0];
        r.tz = tz[31:0];
        r.ax = ax[17:0];
        r.ay = ay[17:0];
        r.az = az[17:0];
        r.ang = ang[18:0];
        return r;
    endfunction

    // Random request: mostly unit axes and in-range angles, some raw bits
    function automatic rot_req_t random_req();
        rot_req_t r;
        real      fx, fy, fz, len;
        r.tx = $urandom();
        r.ty = $urandom();
        r.tz = $urandom();
        if ($urandom_range(3) == 0)
        begin
            // small vectors keep the arithmetic well inside range
            r.tx = $signed(r.tx) >>> $urandom_range(24, 8);
            r.ty = $signed(r.ty) >>> $urandom_range(24, 8);
            r.tz = $signed(r.tz) >>> $urandom_range(24, 8);
        end
        if ($urandom_range(9) < 7)
        begin
            fx = real'($signed($urandom_range(2000))) - 1000.0;
            fy = real'($signed($urandom_range(2000))) - 1000.0;
            fz = real'($signed($urandom_range(2000))) - 1000.0;
            len = $sqrt(fx * fx + fy * fy + fz * fz);
            if (len < 1.0)
            begin
                fx = 1.0;
                len = 1.0;
            end
            r.ax = 18'($rtoi(fx / len * 65536.0));
            r.ay = 18'($rtoi(fy / len * 65536.0));
            r.az = 18'($rtoi(fz / len * 65536.0));
        end
        else
        begin
            r.ax = 18'($urandom());
            r.ay = 18'($urandom());
            r.az = 18'($urandom());
        end
        if ($urandom_range(9) < 8)
            r.ang = 19'($urandom_range(411776) - 205888);
        else
            r.ang = 19'($urandom());
        return r;
    endfunction

    // Hold until every queued request has gone in and every result is back
    task automatic drain();
        while (pending_reqs.size() > 0 || s_axis_tvalid || expected_vecs.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        int idle_set [4];
        int stall_set [4];
        idle_set  = '{0, 51, 0, 31};
        stall_set = '{0, 0, 51, 31};
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        req_taken     = 1'b0;
        idle_pct      = 0;
        stall_pct     = 0;
        err_count     = 0;
        checked_count = 0;
        clipped_count = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: zero vector, field extremes, half-pi fold edges, angles past pi,
        // non-unit axes and forced saturation
        pending_reqs.push_back(make_req(0, 0, 0, 65536, 0, 0, 0));
        pending_reqs.push_back(make_req(65536, 0, 0, 0, 0, 65536, 102943));
        pending_reqs.push_back(make_req(65536, 0, 0, 0, 0, 65536, 102944));
        pending_reqs.push_back(make_req(0, 65536, 0, 65536, 0, 0, -102943));
        pending_reqs.push_back(make_req(0, 65536, 0, 65536, 0, 0, -102944));
        pending_reqs.push_back(make_req(0, 0, 65536, 0, 65536, 0, 205888));
        pending_reqs.push_back(make_req(0, 0, 65536, 0, 65536, 0, -205888));
        pending_reqs.push_back(make_req(2147483647, 2147483647, 2147483647,
                                        0, 0, 65536, 262143));
        pending_reqs.push_back(make_req(-2147483648, -2147483648, -2147483648,
                                        0, -65536, 0, -262144));
        pending_reqs.push_back(make_req(2147483647, -2147483648, 2147483647,
                                        -65536, 0, 0, 51472));
        pending_reqs.push_back(make_req(2147483647, 2147483647, 2147483647,
                                        131071, 131071, 131071, 102944));
        pending_reqs.push_back(make_req(-2147483648, -2147483648, -2147483648,
                                        -131072, -131072, -131072, -205888));
        pending_reqs.push_back(make_req(-2147483648, 2147483647, -1,
                                        -131072, 131071, -131072, 262143));
        pending_reqs.push_back(make_req(1, -1, 1, 37837, 37837, 37837, 1));
        pending_reqs.push_back(make_req(123456789, -98765432, 55555555,
                                        37837, -37837, 37837, -1));
        pending_reqs.push_back(make_req(2147483647, 0, 0, 46341, 46341, 0, 205887));
        pending_reqs.push_back(make_req(0, 0, 0, 0, 0, 0, -262144));
        pending_reqs.push_back(make_req(-65536, 65536, -65536, 0, 0, 0, 150000));
        drain();

        // Random phases, each with its own idling pattern
        for (int p = 0; p < 4; p++)
        begin
            idle_pct  = idle_set[p];
            stall_pct = stall_set[p];
            for (int n = 0; n < 275; n++)
                pending_reqs.push_back(random_req());
            drain();
        end

        repeat (40) @(posedge clk);
        $display("checked %0d rotated vectors over four idling phases, %0d of them clipped",
                 checked_count, clipped_count);
        if (err_count == 0 && expected_vecs.size() == 0)
            $display("vector_axis_angle_rotation verification clean");
        else
            $display("vector_axis_angle_rotation verification failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("vector_axis_angle_rotation verification failed");
        $finish;
    end

endmodule
